// ===== sv/tshe_pkg.sv =====
// Package: status codes, segment layout constants and shared types.
`timescale 1ns / 1ps

package tshe_pkg;

    localparam int unsigned HDR_BYTES       = 9;
    localparam logic [7:0]  REC_HANDSHAKE   = 8'd22;
    localparam logic [7:0]  MSG_SERVERHELLO = 8'd2;
    localparam logic [15:0] POS_REC_KIND    = 16'd0;
    localparam logic [15:0] POS_MSG_KIND    = 16'd5;
    localparam logic [15:0] POS_LEN_FIRST   = 16'd6;
    localparam logic [15:0] POS_LEN_LAST    = 16'd8;
    localparam logic [15:0] POS_VER_MAJOR   = 16'd9;
    localparam logic [15:0] POS_VER_MINOR   = 16'd10;
    localparam logic [15:0] POS_SID_LEN     = 16'd43;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_DISABLED  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_NOT_HS    = 3'd3,
        ST_NOT_HELLO = 3'd4,
        ST_PARTIAL   = 3'd5
    } t_status;

    typedef struct packed {
        logic valid;
        logic last;
    } t_step;

    typedef struct packed {
        t_status     status;
        logic [15:0] hello_version;
        logic [15:0] chosen_cipher;
        logic [7:0]  chosen_compression;
    } t_result;

endpackage

// ===== sv/tshe_if.sv =====
// Channel interfaces: input word, result word and configuration write.
`timescale 1ns / 1ps

interface tshe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       segment_end;

    modport source (output valid, payload_byte, segment_end, input ready);
    modport sink   (input valid, payload_byte, segment_end, output ready);
endinterface

interface tshe_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] hello_version;
    logic [15:0] chosen_cipher;
    logic [7:0]  chosen_compression;

    modport source (output valid, status, hello_version, chosen_cipher,
                    chosen_compression, input ready);
    modport sink   (input valid, status, hello_version, chosen_cipher,
                    chosen_compression, output ready);
endinterface

interface tshe_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/tshe_parser.sv =====
// Segment parser: byte counter, field captures and end-of-segment status.
`timescale 1ns / 1ps

module tshe_parser
    import tshe_pkg::*;
#(
    parameter int unsigned MAX_SEGMENT_BYTES = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step      i_step,
    input  logic [7:0] i_byte,
    input  logic       i_enable,
    output t_result    o_result
);

    localparam logic [15:0] MaxPos = 16'(MAX_SEGMENT_BYTES);

    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_rec, n_rec;
    logic [7:0]  r_msg, n_msg;
    logic [23:0] r_body, n_body;
    logic [15:0] r_ver, n_ver;
    logic [7:0]  r_sid, n_sid;
    logic [15:0] r_cipher, n_cipher;
    logic [7:0]  r_comp, n_comp;
    logic        r_comp_seen, n_comp_seen;

    logic        capture;
    logic [15:0] cpos;
    logic [24:0] need_len;
    t_status     status;

    always_comb begin
        capture     = r_pos < MaxPos;
        cpos        = POS_SID_LEN + 16'd1 + {8'd0, r_sid};
        n_pos       = r_pos;
        n_rec       = r_rec;
        n_msg       = r_msg;
        n_body      = r_body;
        n_ver       = r_ver;
        n_sid       = r_sid;
        n_cipher    = r_cipher;
        n_comp      = r_comp;
        n_comp_seen = r_comp_seen;
        if (capture) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == POS_REC_KIND) begin
                n_rec = i_byte;
            end else if (r_pos == POS_MSG_KIND) begin
                n_msg = i_byte;
            end else if (r_pos >= POS_LEN_FIRST && r_pos <= POS_LEN_LAST) begin
                n_body = {r_body[15:0], i_byte};
            end else if (r_pos == POS_VER_MAJOR) begin
                n_ver = {i_byte, r_ver[7:0]};
            end else if (r_pos == POS_VER_MINOR) begin
                n_ver = {r_ver[15:8], i_byte};
            end else if (r_pos == POS_SID_LEN) begin
                n_sid = i_byte;
            end else if (r_pos == cpos) begin
                n_cipher = {i_byte, r_cipher[7:0]};
            end else if (r_pos == cpos + 16'd1) begin
                n_cipher = {r_cipher[15:8], i_byte};
            end else if (r_pos == cpos + 16'd2) begin
                n_comp      = i_byte;
                n_comp_seen = 1'b1;
            end
        end
    end

    always_comb begin
        need_len = 25'(HDR_BYTES) + {1'b0, n_body};
        if (!i_enable) begin
            status = ST_DISABLED;
        end else if (n_pos < 16'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (n_rec != REC_HANDSHAKE) begin
            status = ST_NOT_HS;
        end else if (n_msg != MSG_SERVERHELLO) begin
            status = ST_NOT_HELLO;
        end else if ({9'd0, n_pos} < need_len) begin
            status = ST_PARTIAL;
        end else if (!n_comp_seen) begin
            status = ST_PARTIAL;
        end else begin
            status = ST_FOUND;
        end
        o_result.status = status;
        if (status == ST_FOUND) begin
            o_result.hello_version      = n_ver;
            o_result.chosen_cipher      = n_cipher;
            o_result.chosen_compression = n_comp;
        end else begin
            o_result.hello_version      = '0;
            o_result.chosen_cipher      = '0;
            o_result.chosen_compression = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last)) begin
            r_pos       <= '0;
            r_rec       <= '0;
            r_msg       <= '0;
            r_body      <= '0;
            r_ver       <= '0;
            r_sid       <= '0;
            r_cipher    <= '0;
            r_comp      <= '0;
            r_comp_seen <= 1'b0;
        end else if (i_step.valid) begin
            r_pos       <= n_pos;
            r_rec       <= n_rec;
            r_msg       <= n_msg;
            r_body      <= n_body;
            r_ver       <= n_ver;
            r_sid       <= n_sid;
            r_cipher    <= n_cipher;
            r_comp      <= n_comp;
            r_comp_seen <= n_comp_seen;
        end
    end

endmodule

// ===== sv/tls_server_hello_extractor.sv =====
// Top level: input register, parser and result register with handshakes.
//
//  channel  dir  payload                                                 
//  i_in     in   payload_byte[7:0], segment_end                          
//  o_out    out  status[2:0], hello_version, chosen_cipher, chosen_compression
//  i_cfg    in   data = analysis_enable                                  
//
// One word per cycle unless a held result stalls; the result word is registered.
// The parser register stage sets the rate: one byte updates the captures per clock.
// Synchronous active-low reset clears the segment state, enable and valids.
// A held result stalls only a last word; other words keep flowing behind it.
`timescale 1ns / 1ps

module tls_server_hello_extractor
    import tshe_pkg::*;
#(
    parameter int unsigned MAX_SEGMENT_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tshe_in_if.sink     i_in,
    tshe_out_if.source  o_out,
    tshe_cfg_if.sink    i_cfg
);

    logic       r_enable;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       s_fire;
    t_step      step;
    t_result    result;

    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_version;
    logic [15:0] r_cipher;
    logic [7:0]  r_comp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.data;
        end
    end

    assign s_fire     = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_fire;
    assign step.valid = s_fire;
    assign step.last  = r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (s_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.payload_byte;
            r_in_last <= i_in.segment_end;
        end
    end

    tshe_parser #(
        .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_enable(r_enable),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && r_in_last) begin
            r_status  <= result.status;
            r_version <= result.hello_version;
            r_cipher  <= result.chosen_cipher;
            r_comp    <= result.chosen_compression;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_status;
    assign o_out.hello_version      = r_version;
    assign o_out.chosen_cipher      = r_cipher;
    assign o_out.chosen_compression = r_comp;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && r_in_last |-> !r_out_valid || o_out.ready)
        else $error("result register overwritten while held");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_fire && r_in_last))
        else $error("result appeared without a last word");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_FOUND |->
            r_version == 16'd0 && r_cipher == 16'd0 && r_comp == 8'd0)
        else $error("fields nonzero on a status other than found");
`endif

endmodule
